@@ rtl/ray_sphere_intersect_macros.svh @@
// Assertion macros shared by the ray/sphere intersection RTL.
// Expects signals named clock and reset in the including module.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define RSI_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define RSI_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rsi_pkg.sv @@
// Shared constants for the ray/sphere intersection block.
// No dependencies; imported by rsi_mul, ray_sphere_intersect, the checker and the testbench.
package rsi_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int LIMB_BITS       = 32;

   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;
endpackage

@@ rtl/rsi_mul.sv @@
// Three-stage pipelined signed multiplier built from limb partial products.
// Depends on rsi_pkg (LIMB_BITS).
module rsi_mul #(
   parameter int WA = 32,
   parameter int WB = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);
   import rsi_pkg::*;

   localparam int L   = LIMB_BITS;
   localparam int NLA = (WA + L - 1) / L;
   localparam int NLB = (WB + L - 1) / L;
   localparam int AXW = NLA * L;
   localparam int BXW = NLB * L;
   localparam int PW  = 2 * L + 2;
   localparam int WX  = AXW + BXW + 2;

   logic signed [AXW-1:0] a_ext;
   logic signed [BXW-1:0] b_ext;
   logic signed [L:0]     la [NLA];
   logic signed [L:0]     lb [NLB];
   logic signed [PW-1:0]  pp_ff [NLA][NLB];
   logic signed [WX-1:0]  row_in [NLA];
   logic signed [WX-1:0]  row_ff [NLA];
   logic signed [WX-1:0]  p_in;
   logic signed [WX-1:0]  p_ff;

   assign a_ext = AXW'(a);
   assign b_ext = BXW'(b);

   // top limb carries the sign, lower limbs are plain magnitudes
   always_comb begin
      for (int i = 0; i < NLA; i++) begin
         la[i] = (i == NLA - 1) ? {a_ext[i*L+L-1], a_ext[i*L +: L]} : {1'b0, a_ext[i*L +: L]};
      end
      for (int j = 0; j < NLB; j++) begin
         lb[j] = (j == NLB - 1) ? {b_ext[j*L+L-1], b_ext[j*L +: L]} : {1'b0, b_ext[j*L +: L]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NLA; i++) begin
            for (int j = 0; j < NLB; j++) begin
               pp_ff[i][j] <= la[i] * lb[j];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NLA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NLB; j++) begin
            row_in[i] = row_in[i] + (WX'(pp_ff[i][j]) <<< (j * L));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff <= row_in;
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NLA; i++) begin
         p_in = p_in + (row_ff[i] <<< (i * L));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff[WA+WB-1:0];
endmodule

@@ rtl/ray_sphere_intersect.sv @@
// Top level of the ray/sphere intersection pipeline with its register port.
// Depends on rsi_pkg, rsi_mul and ray_sphere_intersect_macros.svh.
//
// Takes one ray per cycle and returns, for each ray in order, the nearer root t of
// |o + t*d - c|^2 = r^2 in signed fixed point, or a miss (hit low, t = -1.0) when
// the discriminant is not positive or the direction is zero. Every step is exact:
// products come from limb multipliers, the integer square root and the division
// each run one result bit per stage, and t is the floor of the exact quotient,
// saturated to the coordinate range with clipped set; the defaults give t in Q16.16.
// The pipeline has 2*COORD_WIDTH+4 square-root and 2*COORD_WIDTH+6+FRAC_BITS divider
// stages and holds as a whole while a result beat waits on rsp_tready.
// Write center and radius only while no ray is in flight.
`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF,
   localparam int CSR_DW     = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int CSR_SH     = (COORD_WIDTH > 32) ? 3 : 2,
   localparam int CSR_AW     = CSR_SH + 2,
   localparam int IN_DW      = ((6 * COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_DW     = ((COORD_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [IN_DW-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // distance
   output logic [OUT_DW-1:0] rsp_tdata,
   // hit, clipped
   output logic [1:0]        rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   import rsi_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int VW  = W + 1;          // o - c
   localparam int AW  = 2 * W + 2;      // A = d.d
   localparam int BW  = 2 * W + 3;      // b = v.d
   localparam int CW  = 2 * W + 5;      // C = v.v - r^2
   localparam int ND  = 4 * W + 8;      // discriminant b^2 - A*C
   localparam int NR  = ND / 2;         // root bits
   localparam int RMW = NR + 2;         // root remainder
   localparam int NW  = 2 * W + 6;      // -b - q
   localparam int NN  = NW + F;         // scaled numerator magnitude
   localparam int QW  = 2 * W;          // divisor width
   localparam int TW  = NN + 2;
   localparam int LAT = 12 + NR + NN;

   localparam logic [W-1:0] MISS_T  = {{(W - F){1'b1}}, {F{1'b0}}};
   localparam logic [W-1:0] T_MIN   = {1'b1, {(W - 1){1'b0}}};
   localparam logic [W-1:0] T_MAX   = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-2:0] R_RESET = (W - 1)'(1) << F;

   // ---------------------------------------------------------------- registers
   logic [W-1:0]        center_ff [3];
   logic [W-2:0]        radius_ff;
   logic                csr_wr;
   logic [1:0]          csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_AW-1:CSR_SH];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= R_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CENTER_X: center_ff[0] <= csr_pwdata[W-1:0];
            REG_CENTER_Y: center_ff[1] <= csr_pwdata[W-1:0];
            REG_CENTER_Z: center_ff[2] <= csr_pwdata[W-1:0];
            REG_RADIUS:   radius_ff    <= csr_pwdata[W-2:0];
            default:      radius_ff    <= radius_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CENTER_X: csr_prdata = CSR_DW'(center_ff[0]);
         REG_CENTER_Y: csr_prdata = CSR_DW'(center_ff[1]);
         REG_CENTER_Z: csr_prdata = CSR_DW'(center_ff[2]);
         REG_RADIUS:   csr_prdata = CSR_DW'(radius_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   // Advance every stage together; hold everything while the output beat waits.
   logic           pipe_en;
   logic [LAT-1:0] vld_ff;

   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---------------------------------------------------------------- v = o - c
   logic signed [VW-1:0] v_ff [3];
   logic signed [W-1:0]  d_ff [3];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= VW'($signed(req_tdata[i*W +: W])) - VW'($signed(center_ff[i]));
            d_ff[i] <= $signed(req_tdata[(3+i)*W +: W]);
         end
      end
   end

   // ---------------------------------------------------------------- products
   logic signed [2*W-1:0]    dd_p [3];
   logic signed [VW+W-1:0]   vd_p [3];
   logic signed [2*VW-1:0]   vv_p [3];
   logic signed [2*W-1:0]    rr_p;
   logic signed [W-1:0]      r_s;

   assign r_s = $signed({1'b0, radius_ff});

   for (genvar i = 0; i < 3; i++) begin : g_prod
      rsi_mul #(.WA(W), .WB(W)) u_dd (
         .clock(clock), .en(pipe_en), .a(d_ff[i]), .b(d_ff[i]), .p(dd_p[i]));
      rsi_mul #(.WA(VW), .WB(W)) u_vd (
         .clock(clock), .en(pipe_en), .a(v_ff[i]), .b(d_ff[i]), .p(vd_p[i]));
      rsi_mul #(.WA(VW), .WB(VW)) u_vv (
         .clock(clock), .en(pipe_en), .a(v_ff[i]), .b(v_ff[i]), .p(vv_p[i]));
   end

   rsi_mul #(.WA(W), .WB(W)) u_rr (
      .clock(clock), .en(pipe_en), .a(r_s), .b(r_s), .p(rr_p));

   // ---------------------------------------------------------------- A, b, C
   logic signed [AW-1:0] a_ff;
   logic signed [BW-1:0] b_ff;
   logic signed [CW-1:0] c_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_ff <= AW'(dd_p[0]) + AW'(dd_p[1]) + AW'(dd_p[2]);
         b_ff <= BW'(vd_p[0]) + BW'(vd_p[1]) + BW'(vd_p[2]);
         c_ff <= CW'(vv_p[0]) + CW'(vv_p[1]) + CW'(vv_p[2]) - CW'(rr_p);
      end
   end

   // ---------------------------------------------------------------- b^2 and A*C
   logic signed [2*BW-1:0]  bb_p;
   logic signed [AW+CW-1:0] ac_p;
   logic signed [AW-1:0]    a_dl_ff [3];
   logic signed [BW-1:0]    b_dl_ff [3];

   rsi_mul #(.WA(BW), .WB(BW)) u_bb (
      .clock(clock), .en(pipe_en), .a(b_ff), .b(b_ff), .p(bb_p));
   rsi_mul #(.WA(AW), .WB(CW)) u_ac (
      .clock(clock), .en(pipe_en), .a(a_ff), .b(c_ff), .p(ac_p));

   // delay A and b alongside the multipliers
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_dl_ff[0] <= a_ff;
         b_dl_ff[0] <= b_ff;
         for (int i = 1; i < 3; i++) begin
            a_dl_ff[i] <= a_dl_ff[i-1];
            b_dl_ff[i] <= b_dl_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- discriminant
   logic signed [ND-1:0] dsc_ff;
   logic signed [AW-1:0] a8_ff;
   logic signed [BW-1:0] b8_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dsc_ff <= ND'(bb_p) - ND'(ac_p);
         a8_ff  <= a_dl_ff[2];
         b8_ff  <= b_dl_ff[2];
      end
   end

   // ---------------------------------------------------------------- square root
   // One root bit per stage: bring down two radicand bits, try 4q+1.
   logic [ND-1:0]        sn_ff    [NR+1];
   logic [RMW-1:0]       srem_ff  [NR+1];
   logic [NR-1:0]        sroot_ff [NR+1];
   logic signed [AW-1:0] sa_ff    [NR+1];
   logic signed [BW-1:0] sb_ff    [NR+1];
   logic                 smiss_ff [NR+1];
   logic                 miss_in;

   assign miss_in = (a8_ff == '0) || dsc_ff[ND-1] || (dsc_ff == '0);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sn_ff[0]    <= miss_in ? '0 : dsc_ff;
         srem_ff[0]  <= '0;
         sroot_ff[0] <= '0;
         sa_ff[0]    <= a8_ff;
         sb_ff[0]    <= b8_ff;
         smiss_ff[0] <= miss_in;
      end
   end

   for (genvar k = 0; k < NR; k++) begin : g_sq
      logic [RMW+1:0] rem2;
      logic [RMW+1:0] trial;
      logic           ge;

      assign rem2  = {srem_ff[k], sn_ff[k][ND-1 -: 2]};
      assign trial = (RMW + 2)'({sroot_ff[k], 2'b01});
      assign ge    = rem2 >= trial;

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            srem_ff[k+1]  <= ge ? RMW'(rem2 - trial) : RMW'(rem2);
            sroot_ff[k+1] <= {sroot_ff[k][NR-2:0], ge};
            sn_ff[k+1]    <= sn_ff[k] << 2;
            sa_ff[k+1]    <= sa_ff[k];
            sb_ff[k+1]    <= sb_ff[k];
            smiss_ff[k+1] <= smiss_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------- numerator
   logic signed [NW-1:0] num_val;
   logic signed [NN-1:0] num_scl;
   logic                 num_neg;

   assign num_val = -NW'(sb_ff[NR]) - $signed(NW'(sroot_ff[NR]));
   assign num_scl = {num_val, {F{1'b0}}};
   assign num_neg = num_val[NW-1];

   // ---------------------------------------------------------------- divider
   // Restoring division of |num| by A, one quotient bit per stage.
   logic [NN-1:0] dn_ff    [NN+1];
   logic [QW-1:0] drem_ff  [NN+1];
   logic [NN-1:0] dq_ff    [NN+1];
   logic [QW-1:0] da_ff    [NN+1];
   logic          dneg_ff  [NN+1];
   logic          dmiss_ff [NN+1];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dn_ff[0]    <= num_neg ? NN'(-num_scl) : NN'(num_scl);
         drem_ff[0]  <= '0;
         dq_ff[0]    <= '0;
         da_ff[0]    <= sa_ff[NR][QW-1:0];
         dneg_ff[0]  <= num_neg;
         dmiss_ff[0] <= smiss_ff[NR];
      end
   end

   for (genvar k = 0; k < NN; k++) begin : g_div
      logic [QW:0] r2;
      logic [QW:0] dvs;
      logic        ge;

      assign r2  = {drem_ff[k], dn_ff[k][NN-1]};
      assign dvs = {1'b0, da_ff[k]};
      assign ge  = r2 >= dvs;

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            drem_ff[k+1]  <= ge ? QW'(r2 - dvs) : QW'(r2);
            dq_ff[k+1]    <= {dq_ff[k][NN-2:0], ge};
            dn_ff[k+1]    <= dn_ff[k] << 1;
            da_ff[k+1]    <= da_ff[k];
            dneg_ff[k+1]  <= dneg_ff[k];
            dmiss_ff[k+1] <= dmiss_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------- floor, saturate
   logic [TW-1:0] t_mag;
   logic [TW-1:0] t_val;
   logic          t_fits;
   logic [W-1:0]  dist_in;
   logic          clip_in;
   logic [W-1:0]  dist_ff;
   logic          hit_ff;
   logic          clip_ff;

   // negative quotients round toward minus infinity: bump the magnitude on a remainder
   assign t_mag  = TW'(dq_ff[NN]) + TW'(drem_ff[NN] != '0);
   assign t_val  = dneg_ff[NN] ? -t_mag : TW'(dq_ff[NN]);
   assign t_fits = (&t_val[TW-1:W-1]) || !(|t_val[TW-1:W-1]);

   always_comb begin
      if (dmiss_ff[NN]) begin
         dist_in = MISS_T;
         clip_in = 1'b0;
      end else if (t_fits) begin
         dist_in = t_val[W-1:0];
         clip_in = 1'b0;
      end else begin
         dist_in = t_val[TW-1] ? T_MIN : T_MAX;
         clip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dist_ff <= dist_in;
         hit_ff  <= !dmiss_ff[NN];
         clip_ff <= clip_in;
      end
   end

   assign rsp_tdata = OUT_DW'(dist_ff);
   assign rsp_tuser = {clip_ff, hit_ff};

   // ---------------------------------------------------------------- checks
   `RSI_CHECK_NOW(a_miss_beat, rsp_tvalid && !hit_ff, dist_ff == MISS_T && !clip_ff, "miss beat carries a distance other than -1.0")
   `RSI_CHECK_NOW(a_clip_hit, rsp_tvalid && clip_ff, hit_ff, "clipped set on a miss")
   `RSI_CHECK_NEXT(a_stall_hold, !pipe_en, $stable(vld_ff) && $stable(dist_ff), "pipeline moved while stalled")
endmodule

@@ sim/ray_sphere_intersect_checker.sv @@
// Checker for ray_sphere_intersect: mirrors the sphere registers from the CSR port,
// predicts t for every accepted ray beat and compares result beats in order.
// Depends on rsi_pkg for the register codes.
module ray_sphere_intersect_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [191:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rsi_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
      logic        clipped;
   } hit_type;

   logic signed [31:0] sph_cx, sph_cy, sph_cz;
   logic        [30:0] sph_r;
   hit_type            hits_due[$];

   function automatic logic [255:0] int_sqrt(logic [255:0] n);
      logic [255:0] root;
      logic [255:0] probe;
      root  = '0;
      probe = 256'd1 << 254;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Nearer root t = floor((-b - isqrt(b*b - A*C)) * 2^16 / A), saturated.
   function automatic hit_type nearest_hit(logic [191:0] ray);
      wide_type o [3];
      wide_type d [3];
      wide_type c [3];
      wide_type v, a_sum, b_sum, c_sum, disc, num, quot, rem;
      hit_type  res;
      c[0] = wide_type'(sph_cx);
      c[1] = wide_type'(sph_cy);
      c[2] = wide_type'(sph_cz);
      a_sum = 0;
      b_sum = 0;
      c_sum = 0;
      for (int i = 0; i < 3; i++) begin
         o[i]  = wide_type'($signed(ray[32*i +: 32]));
         d[i]  = wide_type'($signed(ray[96 + 32*i +: 32]));
         v     = o[i] - c[i];
         a_sum = a_sum + d[i] * d[i];
         b_sum = b_sum + v * d[i];
         c_sum = c_sum + v * v;
      end
      c_sum = c_sum - wide_type'({1'b0, sph_r}) * wide_type'({1'b0, sph_r});
      disc  = b_sum * b_sum - a_sum * c_sum;
      res.clipped = 1'b0;
      if (a_sum == 0 || disc <= 0) begin
         res.hit      = 1'b0;
         res.distance = 32'hFFFF_0000;
         return res;
      end
      res.hit = 1'b1;
      num  = (-b_sum - wide_type'(int_sqrt(disc))) * 65536;
      quot = num / a_sum;
      rem  = num % a_sum;
      // round toward minus infinity
      if (rem != 0 && num < 0) quot = quot - 1;
      if (quot < -wide_type'(64'sh8000_0000)) begin
         res.distance = 32'h8000_0000;
         res.clipped  = 1'b1;
      end else if (quot > wide_type'(64'sh7FFF_FFFF)) begin
         res.distance = 32'h7FFF_FFFF;
         res.clipped  = 1'b1;
      end else begin
         res.distance = quot[31:0];
      end
      return res;
   endfunction

   assign pending_count = hits_due.size();

   always @(posedge clock) begin
      hit_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         sph_cx     <= '0;
         sph_cy     <= '0;
         sph_cz     <= '0;
         sph_r      <= 31'd65536;
         fail_count <= 0;
         hits_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_CENTER_X: sph_cx <= csr_pwdata;
               REG_CENTER_Y: sph_cy <= csr_pwdata;
               REG_CENTER_Z: sph_cz <= csr_pwdata;
               REG_RADIUS:   sph_r  <= csr_pwdata[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) hits_due.push_back(nearest_hit(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (hits_due.size() == 0) begin
               $error("result beat with nothing expected: distance %h", rsp_tdata);
               errs = errs + 1;
            end else begin
               want = hits_due.pop_front();
               if (rsp_tuser[0] !== want.hit) begin
                  $error("hit: expected %b, got %b", want.hit, rsp_tuser[0]);
                  errs = errs + 1;
               end
               if (rsp_tdata !== want.distance) begin
                  $error("distance: expected %h, got %h", want.distance, rsp_tdata);
                  errs = errs + 1;
               end
               if (rsp_tuser[1] !== want.clipped) begin
                  $error("clipped: expected %b, got %b", want.clipped, rsp_tuser[1]);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end
endmodule

@@ sim/ray_sphere_intersect_tb.sv @@
// Top of the ray_sphere_intersect testbench: clock, reset, ray stimulus, CSR phases.
// Depends on rsi_pkg, the block itself and ray_sphere_intersect_checker.
module ray_sphere_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsi_pkg::*;

   localparam logic signed [31:0] ONE = 32'sd65536;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // distance
   logic [31:0]  rsp_tdata;
   // hit, clipped
   logic [1:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending_count;

   // stall control for both sides; calm means no idling in that stretch
   bit           send_calm;
   bit           sink_calm;
   int           sink_wait;
   logic signed [31:0] cur_c [3];

   ray_sphere_intersect dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   ray_sphere_intersect_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .fail_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // Result side: after each accepted beat draw a random stall unless calm.
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = sink_calm ? 0 : $urandom_range(0, 12);
         sink_wait  <= w;
         rsp_tready <= (w == 0);
      end else if (sink_wait > 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= (sink_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [191:0] pack_ray(logic [31:0] ox, logic [31:0] oy,
                                             logic [31:0] oz, logic [31:0] dx,
                                             logic [31:0] dy, logic [31:0] dz);
      return {dz, dy, dx, oz, oy, ox};
   endfunction

   // Hold valid until the beat goes through; gap first unless calm.
   task automatic send_ray(logic [191:0] ray);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= ray;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Two-phase register write, then the bus goes idle; pready is tied high.
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the pipeline, then let the clock run on with no rays before touching CSRs.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] r);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS, r);
      cur_c[0] = cx;
      cur_c[1] = cy;
      cur_c[2] = cz;
   endtask

   // Mostly rays aimed near the center, some degenerate or fully random.
   task automatic send_random_ray();
      logic signed [31:0] off [3];
      logic signed [31:0] o [3];
      logic signed [31:0] d [3];
      int pick, span, shr;
      pick = $urandom_range(0, 99);
      span = $urandom_range(8, 23);
      shr  = $urandom_range(0, 12);
      for (int i = 0; i < 3; i++) begin
         off[i] = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
         o[i]   = cur_c[i] + off[i];
         d[i]   = ((-off[i]) >>> shr) + $signed($urandom_range(0, 255)) - 128;
      end
      if (pick < 12) begin
         for (int i = 0; i < 3; i++) begin
            o[i] = $urandom();
            d[i] = $urandom();
         end
      end else if (pick < 17) begin
         d[0] = 0; d[1] = 0; d[2] = 0;
         if (pick == 16) d[$urandom_range(0, 2)] = $urandom_range(0, 3) - 1;
      end else if (pick < 25) begin
         d[$urandom_range(0, 2)] = $urandom();
      end
      send_ray(pack_ray(o[0], o[1], o[2], d[0], d[1], d[2]));
      if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
      if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
   endtask

   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      send_calm   = 1'b0;
      sink_calm   = 1'b0;
      cur_c[0]    = 0;
      cur_c[1]    = 0;
      cur_c[2]    = 0;
      reset       = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rays against the reset sphere (unit radius at the origin).
      send_ray(pack_ray(-5 * ONE, 0, 0, ONE, 0, 0));        // clean hit, t = 4
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0));               // origin inside, root < 0
      send_ray(pack_ray(-5 * ONE, 0, 0, 0, 0, 0));          // zero direction
      send_ray(pack_ray(-5 * ONE, ONE, 0, ONE, 0, 0));      // tangent, discriminant 0
      send_ray(pack_ray(-5 * ONE, 2 * ONE, 0, ONE, 0, 0));  // clear miss
      send_ray(pack_ray(5 * ONE, 0, 0, -ONE, 0, 0));        // hit from the other side
      send_ray(pack_ray(-30000 * ONE, 0, 0, 1, 0, 0));      // t above range, saturate
      send_ray(pack_ray(30000 * ONE, 0, 0, 1, 0, 0));       // t below range, saturate
      send_ray(pack_ray(0, -3 * ONE, 0, 0, 32'h7FFF_FFFF, 0));
      send_ray(pack_ray(0, 0, 3 * ONE, 0, 0, 32'h8000_0000));
      send_ray(pack_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_ray(pack_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
      send_ray(pack_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_ray(pack_ray(-2 * ONE, -2 * ONE, -2 * ONE, ONE, ONE, ONE));
      for (int k = 0; k < 100; k++) send_random_ray();
      drain();

      // Extreme sphere: far positive corner, largest radius.
      set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0));
      for (int k = 0; k < 120; k++) send_random_ray();
      drain();

      // Far negative corner, zero radius: no ray can hit, since the discriminant is never positive.
      set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
      send_ray(pack_ray(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
      for (int k = 0; k < 120; k++) send_random_ray();
      drain();

      // Random spheres of moderate radius.
      for (int p = 0; p < 3; p++) begin
         set_sphere($signed($urandom_range(0, 2000)) * ONE - 1000 * ONE,
                    $urandom(), $signed($urandom_range(0, 200)) * ONE - 100 * ONE,
                    $urandom_range(1, 50 * 65536));
         for (int k = 0; k < 100; k++) send_random_ray();
         drain();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

@@ ray_sphere_intersect.f @@
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_mul.sv
rtl/ray_sphere_intersect.sv
sim/ray_sphere_intersect_checker.sv
sim/ray_sphere_intersect_tb.sv
